[hw/rtl/dsce_pkg.sv]
// shared types and constants for the decimal seconds clock editor
// no dependencies; imported by dsce_conv and decimal_seconds_clock_editor
package dsce_pkg;

  // number of decimal digits kept, digit 0 most significant
  localparam int DIGIT_COUNT = 10;
  localparam int BCD_W       = 4 * DIGIT_COUNT;
  localparam int SEC_W       = 32;

  // selector code meaning no digit selected
  localparam logic [3:0] SEL_NONE  = 4'd10;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // operation codes on the input word
  localparam logic [2:0] OP_EDGE   = 3'd0;
  localparam logic [2:0] OP_SELECT = 3'd1;
  localparam logic [2:0] OP_UP     = 3'd2;
  localparam logic [2:0] OP_DONE   = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;

  typedef enum logic [1:0] {
    MODE_DISPLAY = 2'd0,
    MODE_EDIT    = 2'd1,
    MODE_WRITING = 2'd2
  } mode_t;

  // command to the conversion unit
  typedef struct packed {
    logic start;
    logic fold;
  } conv_cmd_t;

  // status back from the conversion unit
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

[hw/rtl/dsce_conv.sv]
// iterative binary/decimal conversion unit: shift-add-3 split, times-ten fold
// depends on dsce_pkg
module dsce_conv
  import dsce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  conv_cmd_t        cmd,
  input  logic [SEC_W-1:0] bin_in,
  input  logic [BCD_W-1:0] bcd_in,
  output conv_stat_t       stat,
  output logic [SEC_W-1:0] bin_out,
  output logic [BCD_W-1:0] bcd_out
);

  localparam int SPLIT_STEPS = SEC_W;
  localparam int STEP_W      = $clog2(SPLIT_STEPS + 1);

  logic              busy;
  logic              done;
  logic              fold;
  logic [STEP_W-1:0] cnt;
  logic [SEC_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [SEC_W-1:0]  bin_x10;

  // add three to every nibble of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // fold step: acc * 10 + top digit, modulo 2^32
  assign bin_x10 = {bin[SEC_W-4:0], 3'b000} + {bin[SEC_W-2:0], 1'b0}
                 + {{(SEC_W-4){1'b0}}, bcd[BCD_W-1 -: 4]};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      fold <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        fold <= cmd.fold;
        cnt  <= cmd.fold ? STEP_W'(DIGIT_COUNT) : STEP_W'(SPLIT_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shared working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bin <= cmd.fold ? '0 : bin_in;
      bcd <= cmd.fold ? bcd_in : '0;
    end else if (busy) begin
      if (fold) begin
        bin <= bin_x10;
        bcd <= {bcd[BCD_W-5:0], 4'b0000};
      end else begin
        bcd <= {bcd_adj[BCD_W-2:0], bin[SEC_W-1]};
        bin <= {bin[SEC_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign bin_out   = bin;
  assign bcd_out   = bcd;

endmodule

[hw/rtl/decimal_seconds_clock_editor.sv]
// top level of the decimal seconds clock editor: mode sequencer, digit store
// depends on dsce_pkg and dsce_conv
//
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   operation, selected_digit, load_value
// output    out        out_valid / out_stall mode, digits_bcd, seconds_value,
//                                            commit_valid, commit_seconds
// config    in         cfg_we                cfg_wdata (earliest_time)
//
// a counting edge or load runs 32 shift-add-3 steps in dsce_conv
// a commit runs 10 times-ten fold steps in dsce_conv
// other words skip the converter; one word at a time, in_stall high while busy
// a stalled output holds the finished word and the next one waits behind it
// rst is synchronous: count, digits, mode, phase and earliest_time clear
module decimal_seconds_clock_editor
  import dsce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [SEC_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       operation,
  input  logic [3:0]       selected_digit,
  input  logic [SEC_W-1:0] load_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       mode,
  output logic [BCD_W-1:0] digits_bcd,
  output logic [SEC_W-1:0] seconds_value,
  output logic             commit_valid,
  output logic [SEC_W-1:0] commit_seconds
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_FOLD,
    S_PUBLISH
  } state_t;

  state_t           state;
  mode_t            clock_mode;
  logic             edge_phase;
  logic [SEC_W-1:0] earliest_time;
  logic [SEC_W-1:0] seconds_count;
  logic [3:0]       digit [DIGIT_COUNT];
  logic             commit_pending;
  logic [SEC_W-1:0] commit_val;

  logic             accept;
  logic             publish;
  logic             out_free;
  logic [SEC_W-1:0] count_next;
  logic [BCD_W-1:0] digits_packed;
  conv_cmd_t        conv_cmd;
  conv_stat_t       conv_stat;
  logic [SEC_W-1:0] conv_bin;
  logic [BCD_W-1:0] conv_bcd;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign publish  = (state == S_PUBLISH) && out_free;

  // pack the digit store, digit 0 in the top nibble
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digits_packed[4*(DIGIT_COUNT-1-i) +: 4] = digit[i];
    end
  end

  // new count and conversion request for the accepted word
  always_comb begin
    conv_cmd   = '0;
    count_next = seconds_count;
    if (accept) begin
      unique case (operation)
        OP_EDGE: begin
          count_next = seconds_count + 1'b1;
          conv_cmd.start = !edge_phase && (clock_mode == MODE_DISPLAY);
        end
        OP_SELECT: begin
          conv_cmd.start = (selected_digit == SEL_NONE) && (clock_mode == MODE_EDIT);
          conv_cmd.fold  = 1'b1;
        end
        OP_LOAD: begin
          count_next = (load_value < earliest_time) ? earliest_time : load_value;
          conv_cmd.start = 1'b1;
        end
        default: begin
          conv_cmd = '0;
        end
      endcase
    end
  end

  dsce_conv u_conv (
    .clk     (clk),
    .rst     (rst),
    .cmd     (conv_cmd),
    .bin_in  (count_next),
    .bcd_in  (digits_packed),
    .stat    (conv_stat),
    .bin_out (conv_bin),
    .bcd_out (conv_bcd)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      earliest_time <= '0;
    end else if (cfg_we) begin
      earliest_time <= cfg_wdata;
    end
  end

  // sequencer, clock state and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      clock_mode     <= MODE_DISPLAY;
      edge_phase     <= 1'b0;
      seconds_count  <= '0;
      commit_pending <= 1'b0;
      out_valid      <= 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && !publish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            commit_pending <= conv_cmd.start && conv_cmd.fold;
            commit_val     <= '0;
            // split or fold when the word needs the converter, else straight out
            if (conv_cmd.start) begin
              state <= conv_cmd.fold ? S_FOLD : S_SPLIT;
            end else begin
              state <= S_PUBLISH;
            end
            unique case (operation)
              OP_EDGE: begin
                edge_phase <= !edge_phase;
                if (conv_cmd.start) begin
                  seconds_count <= count_next;
                end
              end
              OP_SELECT: begin
                if (selected_digit != SEL_NONE) begin
                  if (clock_mode != MODE_WRITING) begin
                    clock_mode <= MODE_EDIT;
                  end
                end else if (clock_mode == MODE_EDIT) begin
                  clock_mode <= MODE_WRITING;
                end
              end
              OP_UP: begin
                if (clock_mode != MODE_WRITING) begin
                  if (selected_digit < SEL_NONE) begin
                    digit[selected_digit] <= (digit[selected_digit] >= DIGIT_MAX) ?
                                             4'd0 : digit[selected_digit] + 4'd1;
                  end
                  clock_mode <= MODE_EDIT;
                end
              end
              OP_DONE: begin
                if (clock_mode == MODE_WRITING) begin
                  clock_mode <= MODE_DISPLAY;
                end
              end
              OP_LOAD: begin
                seconds_count <= count_next;
              end
              default: begin
              end
            endcase
          end
        end
        S_SPLIT: begin
          if (conv_stat.done) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
              digit[i] <= conv_bcd[4*(DIGIT_COUNT-1-i) +: 4];
            end
            state <= S_PUBLISH;
          end
        end
        S_FOLD: begin
          if (conv_stat.done) begin
            seconds_count <= conv_bin;
            commit_val    <= conv_bin;
            state         <= S_PUBLISH;
          end
        end
        S_PUBLISH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            mode           <= clock_mode;
            digits_bcd     <= digits_packed;
            seconds_value  <= seconds_count;
            commit_valid   <= commit_pending;
            commit_seconds <= commit_val;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a commit is only ever reported together with writing mode
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && commit_valid) |-> (mode == MODE_WRITING))
    else $error("commit reported outside writing mode");

  // conversion finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    conv_stat.done |-> (state == S_SPLIT || state == S_FOLD))
    else $error("conversion done with no conversion pending");

  // an accepted word blocks the input on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after accepting a word");

  // publishing always presents a word
  assert property (@(posedge clk) disable iff (rst)
    publish |=> out_valid)
    else $error("published word not valid");

  // conversion unit is idle whenever the sequencer is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !conv_stat.busy)
    else $error("conversion running while sequencer idle");
`endif

endmodule
